/* sv/refcounted_page_allocator_macros.svh */
// Assertion macros for the page allocator checker.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication, sampled on clk, off during reset.
`define RPA_ASSERT_TWO(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

/* sv/rpa_pkg.sv */
`default_nettype none
package rpa_pkg;

	// Operation codes
	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;
	localparam logic [1:0] FUNC_SEED  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;
	localparam logic [1:0] ST_ZERO_REF = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_MEM_BASE   = 2'd0;
	localparam logic [1:0] CFG_FIRST_FREE = 2'd1;
	localparam logic [1:0] CFG_MEM_TOP    = 2'd2;

	localparam logic [31:0] MEM_BASE_RST   = 32'h8000_0000;
	localparam logic [31:0] FIRST_FREE_RST = 32'h8010_0000;
	localparam logic [31:0] MEM_TOP_RST    = 32'h8800_0000;

	typedef enum logic [1:0] {
		SM_CLEAR,
		SM_IDLE,
		SM_RMW
	} state_t;

endpackage
`default_nettype wire

/* sv/rpa_addr_check.sv */
`default_nettype none
module rpa_addr_check #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int IDX_W      = 15
) (
	input  wire logic [31:0]      addr,
	input  wire logic [31:0]      mem_base,
	input  wire logic [31:0]      first_free,
	input  wire logic [31:0]      mem_top,
	output logic                  ok,
	output logic [IDX_W-1:0]      idx
);
	localparam logic [32:0] PAGE_BYTES = 33'd1 << PAGE_SHIFT;

	logic        aligned;
	logic        ge_first;
	logic        ge_base;
	logic        fits;
	logic        in_range;
	logic [31:0] diff;
	logic [31:0] offset;

	always_comb begin
		aligned  = (addr[PAGE_SHIFT-1:0] == '0);
		ge_first = (addr >= first_free);
		ge_base  = (addr >= mem_base);
		fits     = (({1'b0, addr} + PAGE_BYTES) <= {1'b0, mem_top});
		diff     = addr - mem_base;
		offset   = diff >> PAGE_SHIFT;
		in_range = ({1'b0, offset} < 33'(NUM_PAGES));
		ok       = aligned && ge_first && ge_base && fits && in_range;
		idx      = offset[IDX_W-1:0];
	end
endmodule
`default_nettype wire

/* sv/rpa_tables.sv */
`default_nettype none
module rpa_tables #(
	parameter int NUM_PAGES  = 32768,
	parameter int COUNT_BITS = 16,
	parameter int IDX_W      = 15,
	parameter int LINK_W     = 16
) (
	input  wire logic                  clk,
	input  wire logic                  rd_en,
	input  wire logic [IDX_W-1:0]      rd_idx,
	output logic [COUNT_BITS-1:0]      ref_rdata,
	output logic [LINK_W-1:0]          link_rdata,
	input  wire logic                  ref_we,
	input  wire logic [IDX_W-1:0]      ref_widx,
	input  wire logic [COUNT_BITS-1:0] ref_wdata,
	input  wire logic                  link_we,
	input  wire logic [IDX_W-1:0]      link_widx,
	input  wire logic [LINK_W-1:0]     link_wdata
);
	logic [COUNT_BITS-1:0] ref_mem  [NUM_PAGES];
	logic [LINK_W-1:0]     link_mem [NUM_PAGES];

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_widx] <= ref_wdata;
		end
		if (rd_en) begin
			ref_rdata <= ref_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_widx] <= link_wdata;
		end
		if (rd_en) begin
			link_rdata <= link_mem[rd_idx];
		end
	end
endmodule
`default_nettype wire

/* sv/refcounted_page_allocator.sv */
`default_nettype none
// Page frame allocator: LIFO free list with a reference count per page.
// Command channel: func and page_addr are taken at a clock edge with start
// high and busy low. func 0 allocates (pops the head page, count set to 1),
// func 1 frees (count decremented, page pushed when it reaches zero), func 2
// seeds a page at setup (count forced to 1, then freed).
// Result channel: done is high for exactly one cycle with status,
// alloc_addr, released and ref_after; there is no back-pressure.
// Configuration: cfg_we writes cfg_data to the register cfg_index
// (0 mem_base, 1 first_free_addr, 2 mem_top); the user must do this only
// while no item is in flight, as the block does not enforce it.
// Sequence: the edge that accepts an item reads the count and link
// memories at the page's index; in SM_RMW the count and, on a push, the
// link are written back, the head is updated and the result registered,
// so done rises at the edge after the accepting one. busy drops in the
// cycle done is shown, so a new item is taken only after SM_RMW is over.
// Reset: the head becomes empty and the count memory is swept to zero,
// one entry a cycle over all NUM_PAGES entries, with busy held high.
module refcounted_page_allocator #(
	parameter int NUM_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12,
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] page_addr,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      alloc_addr,
	output logic             released,
	output logic [15:0]      ref_after
);
	import rpa_pkg::*;

	localparam int IDX_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int LINK_W = IDX_W + 1;
	localparam int EXT_W  = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	state_t state_q, state_d;

	logic [31:0] mem_base_q, first_free_q, mem_top_q;
	logic             head_valid_q;
	logic [IDX_W-1:0] head_index_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             clr_last;

	logic [1:0]       func_s1;
	logic             ok_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             chk_ok;
	logic [IDX_W-1:0] chk_idx;
	logic             accept;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic             item_ok;

	logic [COUNT_BITS-1:0] ref_rdata;
	logic [LINK_W-1:0]     link_rdata;
	logic                  ref_we;
	logic [IDX_W-1:0]      ref_widx;
	logic [COUNT_BITS-1:0] ref_wdata;
	logic                  link_we;
	logic [LINK_W-1:0]     link_wdata;

	// Read-modify-write results
	logic                  op_ref_we;
	logic [COUNT_BITS-1:0] op_ref_wdata;
	logic                  op_push;
	logic                  op_pop;
	logic                  pop_valid;
	logic [IDX_W-1:0]      pop_index;
	logic [COUNT_BITS-1:0] cur_count;
	logic [COUNT_BITS-1:0] new_count;
	logic [EXT_W-1:0]      new_ext;
	logic [1:0]            res_status;
	logic [31:0]           res_addr;
	logic                  res_released;
	logic [15:0]           res_ref;

	logic        done_q;
	logic [1:0]  status_q;
	logic [31:0] alloc_addr_q;
	logic        released_q;
	logic [15:0] ref_after_q;

	rpa_addr_check #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_SHIFT(PAGE_SHIFT),
		.IDX_W     (IDX_W)
	) u_check (
		.addr      (page_addr),
		.mem_base  (mem_base_q),
		.first_free(first_free_q),
		.mem_top   (mem_top_q),
		.ok        (chk_ok),
		.idx       (chk_idx)
	);

	rpa_tables #(
		.NUM_PAGES (NUM_PAGES),
		.COUNT_BITS(COUNT_BITS),
		.IDX_W     (IDX_W),
		.LINK_W    (LINK_W)
	) u_tables (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx),
		.ref_rdata (ref_rdata),
		.link_rdata(link_rdata),
		.ref_we    (ref_we),
		.ref_widx  (ref_widx),
		.ref_wdata (ref_wdata),
		.link_we   (link_we),
		.link_widx (idx_s1),
		.link_wdata(link_wdata)
	);

	assign clr_last = (clr_idx_q == IDX_W'(NUM_PAGES - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SM_CLEAR: begin
				if (clr_last) state_d = SM_IDLE;
			end
			SM_IDLE: begin
				if (start) state_d = SM_RMW;
			end
			SM_RMW: begin
				state_d = SM_IDLE;
			end
			default: state_d = SM_IDLE;
		endcase
	end

	// State outputs and memory port steering
	always_comb begin
		busy      = 1'b1;
		accept    = 1'b0;
		ref_we    = 1'b0;
		ref_widx  = idx_s1;
		ref_wdata = op_ref_wdata;
		link_we   = 1'b0;
		unique case (state_q)
			SM_CLEAR: begin
				ref_we    = 1'b1;
				ref_widx  = clr_idx_q;
				ref_wdata = '0;
			end
			SM_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			SM_RMW: begin
				ref_we  = op_ref_we;
				link_we = op_push;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Allocate reads at the head; free and seed at the checked index
	always_comb begin
		rd_en   = accept;
		rd_idx  = (func == FUNC_ALLOC) ? head_index_q : chk_idx;
		item_ok = (func == FUNC_ALLOC) ? head_valid_q : chk_ok;
	end

	always_comb begin
		cur_count    = (func_s1 == FUNC_SEED) ? COUNT_BITS'(1) : ref_rdata;
		new_count    = cur_count - COUNT_BITS'(1);
		new_ext      = EXT_W'(new_count);
		pop_valid    = (link_rdata != '0);
		pop_index    = pop_valid ? IDX_W'(link_rdata - LINK_W'(1)) : '0;
		link_wdata   = head_valid_q ? (LINK_W'(head_index_q) + LINK_W'(1)) : '0;
		op_ref_we    = 1'b0;
		op_ref_wdata = new_count;
		op_push      = 1'b0;
		op_pop       = 1'b0;
		res_status   = ST_OK;
		res_addr     = '0;
		res_released = 1'b0;
		res_ref      = '0;
		if (func_s1 == FUNC_ALLOC) begin
			if (!ok_s1) begin
				res_status = ST_EMPTY;
			end else begin
				op_pop       = 1'b1;
				op_ref_we    = 1'b1;
				op_ref_wdata = COUNT_BITS'(1);
				res_ref      = 16'd1;
				res_addr     = mem_base_q + (32'(idx_s1) << PAGE_SHIFT);
			end
		end else if (func_s1 == FUNC_FREE || func_s1 == FUNC_SEED) begin
			if (!ok_s1) begin
				res_status = ST_BAD_ADDR;
			end else if (cur_count == '0) begin
				res_status = ST_ZERO_REF;
			end else begin
				op_ref_we = 1'b1;
				res_ref   = new_ext[15:0];
				if (new_count == '0) begin
					op_push      = 1'b1;
					res_released = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SM_CLEAR;
			clr_idx_q    <= '0;
			head_valid_q <= 1'b0;
			head_index_q <= '0;
			mem_base_q   <= MEM_BASE_RST;
			first_free_q <= FIRST_FREE_RST;
			mem_top_q    <= MEM_TOP_RST;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SM_RMW);
			if (state_q == SM_CLEAR) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MEM_BASE:   mem_base_q   <= cfg_data;
					CFG_FIRST_FREE: first_free_q <= cfg_data;
					CFG_MEM_TOP:    mem_top_q    <= cfg_data;
					default: ;
				endcase
			end
			// Advance or push the head
			if (state_q == SM_RMW && op_pop) begin
				head_valid_q <= pop_valid;
				head_index_q <= pop_index;
			end else if (state_q == SM_RMW && op_push) begin
				head_valid_q <= 1'b1;
				head_index_q <= idx_s1;
			end
		end
	end

	// Item in flight and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			ok_s1   <= item_ok;
			idx_s1  <= rd_idx;
		end
		if (state_q == SM_RMW) begin
			status_q     <= res_status;
			alloc_addr_q <= res_addr;
			released_q   <= res_released;
			ref_after_q  <= res_ref;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign alloc_addr = alloc_addr_q;
	assign released   = released_q;
	assign ref_after  = ref_after_q;
endmodule
`default_nettype wire

/* sv/rpa_checker.sv */
`default_nettype none
`include "refcounted_page_allocator_macros.svh"
module rpa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [31:0] alloc_addr,
	input wire logic        released,
	input wire logic [15:0] ref_after
);
	import rpa_pkg::*;

	`RPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after an accepted item")
	`RPA_ASSERT_TWO(a_done_latency, start && !busy, done, "result missing two cycles on")
	`RPA_ASSERT_NOW(a_fail_clean, done && status != ST_OK, alloc_addr == 32'd0 && !released && ref_after == 16'd0, "failed item carries data")
	`RPA_ASSERT_NOW(a_release_zero, done && released, status == ST_OK && ref_after == 16'd0 && alloc_addr == 32'd0, "released page with nonzero count")
	`RPA_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.alloc_addr(alloc_addr),
	.released  (released),
	.ref_after (ref_after)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import rpa_pkg::*;

	localparam int          N_PAGES     = 32768;
	localparam int          PG_SHIFT    = 12;
	localparam logic [31:0] PG_BYTES    = 32'h0000_1000;
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam int          FRESH_START = 300;
	localparam int          CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] addr;
	} page_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] alloc_addr;
		logic        released;
		logic [15:0] ref_after;
	} page_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [31:0] page_addr;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic [1:0]  status;
	logic [31:0] alloc_addr;
	logic        released;
	logic [15:0] ref_after;

	refcounted_page_allocator #(
		.NUM_PAGES (N_PAGES),
		.PAGE_SHIFT(PG_SHIFT),
		.COUNT_BITS(16)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.page_addr (page_addr),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.status    (status),
		.alloc_addr(alloc_addr),
		.released  (released),
		.ref_after (ref_after)
	);

	// Shadow copy of the allocator: registers, free list and counts
	logic [31:0] cur_base;
	logic [31:0] cur_first;
	logic [31:0] cur_top;
	logic        head_ok;
	logic [14:0] head_pg;
	logic [15:0] link_tbl [N_PAGES];
	logic [15:0] cnt_tbl  [N_PAGES];

	page_cmd_t    cmd_q [$];
	page_result_t want_q [$];

	logic item_taken;
	bit   drain_hold;
	int   acc_cnt;
	int   n_err;
	int   fresh_idx;
	int   cyc;

	function automatic bit page_slot(input logic [31:0] a, output logic [14:0] idx);
		logic [31:0] diff;
		diff = a - cur_base;
		idx  = diff[PG_SHIFT +: 15];
		return (a[PG_SHIFT-1:0] == '0) && (a >= cur_first) && (a >= cur_base)
			&& ({1'b0, a} + {1'b0, PG_BYTES} <= {1'b0, cur_top})
			&& ((diff >> PG_SHIFT) < N_PAGES);
	endfunction

	function automatic page_result_t predict_page_op(input logic [1:0] f, input logic [31:0] a);
		page_result_t r;
		logic [14:0]  idx;
		logic [15:0]  lnk;
		r = '0;
		case (f)
			FUNC_ALLOC: begin
				if (!head_ok) begin
					r.status = ST_EMPTY;
				end else begin
					idx = head_pg;
					lnk = link_tbl[idx];
					if (lnk != 16'd0) begin
						head_pg = 15'(lnk - 16'd1);
					end else begin
						head_ok = 1'b0;
						head_pg = '0;
					end
					cnt_tbl[idx] = 16'd1;
					r.ref_after  = 16'd1;
					r.alloc_addr = cur_base + ({17'b0, idx} << PG_SHIFT);
				end
			end
			FUNC_FREE, FUNC_SEED: begin
				if (!page_slot(a, idx)) begin
					r.status = ST_BAD_ADDR;
				end else begin
					if (f == FUNC_SEED)
						cnt_tbl[idx] = 16'd1;
					if (cnt_tbl[idx] == 16'd0) begin
						r.status = ST_ZERO_REF;
					end else begin
						cnt_tbl[idx] = cnt_tbl[idx] - 16'd1;
						r.ref_after  = cnt_tbl[idx];
						if (cnt_tbl[idx] == 16'd0) begin
							// push onto the free list
							link_tbl[idx] = head_ok ? {1'b0, head_pg} + 16'd1 : 16'd0;
							head_pg       = idx;
							head_ok       = 1'b1;
							r.released    = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Driver: one item at a time from cmd_q, changes at the falling edge
	always @(negedge clk) begin
		page_cmd_t c;
		bit steady;
		steady = (acc_cnt >= 100) && (acc_cnt < 250);
		if (arst_n && (!start || item_taken)) begin
			if (drain_hold) begin
				start <= 1'b0;
				if (want_q.size() == 0)
					drain_hold = 1'b0;
			end else if (cmd_q.size() == 0 || (!steady && $urandom_range(99) < 17)) begin
				start <= 1'b0;
			end else begin
				c = cmd_q.pop_front();
				start     <= 1'b1;
				func      <= c.func;
				page_addr <= c.addr;
				// now and then hold off until every result is back
				if (!steady && $urandom_range(39) == 0)
					drain_hold = 1'b1;
			end
		end
		item_taken <= 1'b0;
	end

	// Monitor: check results against the oldest expectation, then log new items
	always @(posedge clk) begin
		page_result_t w;
		if (arst_n && done) begin
			if (want_q.size() == 0) begin
				$error("result with no item outstanding");
				n_err++;
			end else begin
				w = want_q.pop_front();
				if (status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, status);
					n_err++;
				end
				if (alloc_addr !== w.alloc_addr) begin
					$error("alloc_addr: expected %08h, got %08h", w.alloc_addr, alloc_addr);
					n_err++;
				end
				if (released !== w.released) begin
					$error("released: expected %0d, got %0d", w.released, released);
					n_err++;
				end
				if (ref_after !== w.ref_after) begin
					$error("ref_after: expected %0d, got %0d", w.ref_after, ref_after);
					n_err++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			want_q.push_back(predict_page_op(func, page_addr));
			item_taken <= 1'b1;
			acc_cnt++;
		end
	end

	task automatic push_cmd(input logic [1:0] f, input logic [31:0] a);
		cmd_q.push_back('{func: f, addr: a});
	endtask

	task automatic wait_idle;
		do @(negedge clk);
		while (cmd_q.size() != 0 || start || want_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_MEM_BASE:   cur_base  = val;
			CFG_FIRST_FREE: cur_first = val;
			CFG_MEM_TOP:    cur_top   = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(input logic [31:0] base, input logic [31:0] first,
			input logic [31:0] top);
		wait_idle();
		write_reg(CFG_MEM_BASE, base);
		write_reg(CFG_FIRST_FREE, first);
		write_reg(CFG_MEM_TOP, top);
	endtask

	function automatic logic [31:0] fresh_page_addr();
		logic [31:0] a;
		a = cur_base + (32'(fresh_idx) << PG_SHIFT);
		fresh_idx++;
		return a;
	endfunction

	// Aligned seeds only go to fresh pages, so the free list never gets a page twice
	task automatic queue_random(input int count);
		int          pick;
		int          idx;
		logic [31:0] a;
		logic [1:0]  f;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				push_cmd(FUNC_ALLOC, $urandom);
			end else if (pick < 52) begin
				push_cmd(FUNC_SEED, fresh_page_addr());
			end else if (pick < 80) begin
				idx = (fresh_idx > FRESH_START) ?
					$urandom_range(fresh_idx - 1, FRESH_START) : FRESH_START;
				push_cmd(FUNC_FREE, cur_base + (32'(idx) << PG_SHIFT));
			end else if (pick < 84) begin
				push_cmd(FUNC_UNUSED, $urandom);
			end else if (pick < 90) begin
				// seed at a misaligned address: always rejected
				a = $urandom;
				if (a[PG_SHIFT-1:0] == '0)
					a[PG_SHIFT-1:0] = 12'($urandom_range(4095, 1));
				push_cmd(FUNC_SEED, a);
			end else begin
				case ($urandom_range(7))
					0: a = $urandom;
					1: a = cur_first - PG_BYTES;
					2: a = cur_first;
					3: a = (cur_top - PG_BYTES) & ~(PG_BYTES - 32'd1);
					4: a = cur_top & ~(PG_BYTES - 32'd1);
					5: a = cur_base + (32'(N_PAGES) << PG_SHIFT);
					6: a = cur_base - PG_BYTES;
					default: a = (cur_base + (32'(FRESH_START) << PG_SHIFT))
						| 32'($urandom_range(4095, 1));
				endcase
				push_cmd(FUNC_FREE, a);
			end
		end
	endtask

	initial begin
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [31:0] twice;
		arst_n     = 1'b0;
		start      = 1'b0;
		func       = FUNC_ALLOC;
		page_addr  = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_MEM_BASE;
		cfg_data   = '0;
		item_taken = 1'b0;
		drain_hold = 1'b0;
		acc_cnt    = 0;
		n_err      = 0;
		fresh_idx  = FRESH_START;
		cur_base   = MEM_BASE_RST;
		cur_first  = FIRST_FREE_RST;
		cur_top    = MEM_TOP_RST;
		head_ok    = 1'b0;
		head_pg    = '0;
		for (int i = 0; i < N_PAGES; i++)
			cnt_tbl[i] = 16'd0;

		// directed: empty list, zero count, range edges, unused code, pop order
		push_cmd(FUNC_ALLOC,  32'h0000_0000);
		push_cmd(FUNC_FREE,   32'h8010_0000);
		push_cmd(FUNC_SEED,   32'h8010_0000);
		push_cmd(FUNC_SEED,   32'h87FF_F000);
		push_cmd(FUNC_FREE,   32'h8010_0800);
		push_cmd(FUNC_SEED,   32'h8010_0001);
		push_cmd(FUNC_FREE,   32'h800F_F000);
		push_cmd(FUNC_FREE,   32'h8800_0000);
		push_cmd(FUNC_SEED,   32'hFFFF_F000);
		push_cmd(FUNC_FREE,   32'h0000_0000);
		push_cmd(FUNC_UNUSED, 32'hFFFF_FFFF);
		push_cmd(FUNC_ALLOC,  32'h0000_0000);
		push_cmd(FUNC_ALLOC,  32'h0000_0000);
		push_cmd(FUNC_ALLOC,  32'h0000_0000);
		push_cmd(FUNC_FREE,   32'h8010_0000);
		push_cmd(FUNC_FREE,   32'h8010_0000);
		push_cmd(FUNC_FREE,   32'h87FF_F000);
		push_cmd(FUNC_ALLOC,  32'hFFFF_FFFF);
		push_cmd(FUNC_FREE,   32'h87FF_F000);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_random(200);

		// widest window from address zero; listed pages now pop at new addresses
		set_window(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_random(120);

		// window at the very top: the last page overruns the bound
		set_window(32'hF800_0000, 32'hF800_0000, 32'hFFFF_FFFF);
		queue_random(120);

		// empty window: every address is rejected, pops wrap
		set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_random(30);

		set_window(32'h4000_0000, 32'h4018_0000, 32'h4800_0000);
		queue_random(80);

		// seed one page twice: the list gets a loop and keeps returning it
		wait_idle();
		twice = fresh_page_addr();
		push_cmd(FUNC_SEED,  twice);
		push_cmd(FUNC_SEED,  twice);
		push_cmd(FUNC_ALLOC, 32'h0000_0000);
		push_cmd(FUNC_ALLOC, 32'h0000_0000);
		push_cmd(FUNC_ALLOC, 32'h0000_0000);

		wait_idle();
		if (n_err == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/rpa_pkg.sv
sv/rpa_addr_check.sv
sv/rpa_tables.sv
sv/refcounted_page_allocator.sv
sv/rpa_checker.sv
tb/tb.sv
